@@ hdl/hamming_sec_encode_decode_macros.svh @@
// Assertion macros for the Hamming single-error-correcting codec.
// Used by the port checker; expects clk_i and rst_ni in scope.
`ifndef HAMMING_SEC_ENCODE_DECODE_MACROS_SVH
`define HAMMING_SEC_ENCODE_DECODE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Delayed form: the consequent must hold after the antecedent.
`define HSE_ASSERT_DLY2(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> ##2 (cons)) else $error(msg);

`endif

@@ hdl/hse_pkg.sv @@
// Shared types, constants and position tables for the Hamming codec.
// No dependencies; used by every module of the block.
`default_nettype none

package hse_pkg;

  localparam int unsigned MAX_PARITY_BITS = 6;
  localparam int unsigned WORD_W          = 63;
  localparam int unsigned LEN_W           = 6;

  typedef enum logic [0:0] {
    CMD_ENCODE = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e              command;
    logic [LEN_W-1:0]  data_length;
    logic [WORD_W-1:0] word_in;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] word_out;
    logic [LEN_W-1:0]  out_length;
    logic [LEN_W-1:0]  syndrome;
    logic              corrected;
    logic              uncorrectable;
  } rsp_t;

  // Codeword position (from 1) that holds data bit k.
  function automatic int unsigned data_pos(int unsigned k);
    int unsigned cnt;
    int unsigned pos;
    cnt = 0;
    pos = 0;
    for (int unsigned p = 1; p <= WORD_W; p++) begin
      if ((p & (p - 1)) != 0) begin
        if (cnt == k) begin
          pos = p;
        end
        cnt++;
      end
    end
    return pos;
  endfunction

  // Bit j is set when position j+1 is covered by parity bit i.
  function automatic logic [WORD_W-1:0] pos_mask(int unsigned i);
    logic [WORD_W-1:0] mask;
    for (int unsigned j = 0; j < WORD_W; j++) begin
      mask[j] = (((j + 1) >> i) & 1) != 0;
    end
    return mask;
  endfunction

endpackage

`default_nettype wire

@@ hdl/hse_core.sv @@
// Combinational Hamming encode and check-correct-decode for one word.
// Depends on hse_pkg for the word types and position tables.
`default_nettype none

module hse_core #(
  parameter int unsigned MaxParityBits = hse_pkg::MAX_PARITY_BITS
) (
  input  hse_pkg::req_t req_i,
  output hse_pkg::rsp_t rsp_o
);
  import hse_pkg::*;

  localparam int unsigned CodeLen = (1 << MaxParityBits) - 1;
  localparam int unsigned MaxData = CodeLen - MaxParityBits;
  localparam int unsigned RW      = $clog2(MaxParityBits + 1);

  logic [LEN_W-1:0]         m;
  logic [RW-1:0]            r;
  logic [LEN_W-1:0]         n;
  logic [WORD_W-1:0]        data_mask;
  logic [WORD_W-1:0]        code_mask;
  logic [WORD_W-1:0]        placed;
  logic [WORD_W-1:0]        enc_word;
  logic [MaxParityBits-1:0] parity;
  logic [WORD_W-1:0]        cw;
  logic [MaxParityBits-1:0] syn;
  logic [LEN_W-1:0]         syn_ext;
  logic                     corr;
  logic                     unc;
  logic [WORD_W-1:0]        fixed;
  logic [WORD_W-1:0]        dec_word;

  always_comb begin
    m = req_i.data_length;
    if (m == '0) begin
      m = LEN_W'(1);
    end
    if (m > LEN_W'(MaxData)) begin
      m = LEN_W'(MaxData);
    end

    r = '0;
    for (int unsigned i = 0; i < MaxParityBits; i++) begin
      if (r == RW'(i) &&
          (((LEN_W + 1)'(1) << i) < ({1'b0, m} + (LEN_W + 1)'(i) + (LEN_W + 1)'(1)))) begin
        r = RW'(i + 1);
      end
    end
    n = m + LEN_W'(r);

    for (int unsigned j = 0; j < WORD_W; j++) begin
      data_mask[j] = LEN_W'(j) < m;
      code_mask[j] = LEN_W'(j) < n;
    end

    // Encode path.
    placed = '0;
    for (int unsigned k = 0; k < MaxData; k++) begin
      placed[data_pos(k) - 1] = req_i.word_in[k] & data_mask[k];
    end
    for (int unsigned i = 0; i < MaxParityBits; i++) begin
      parity[i] = ^(placed & pos_mask(i));
    end
    enc_word = placed;
    for (int unsigned i = 0; i < MaxParityBits; i++) begin
      enc_word[(1 << i) - 1] = parity[i];
    end

    // Decode path.
    cw = req_i.word_in & code_mask;
    for (int unsigned i = 0; i < MaxParityBits; i++) begin
      syn[i] = ^(cw & pos_mask(i));
    end
    syn_ext = LEN_W'(syn);
    corr = (syn_ext != '0) && (syn_ext <= n);
    unc  = (syn_ext != '0) && (syn_ext > n);
    fixed = cw;
    for (int unsigned j = 0; j < CodeLen; j++) begin
      if (corr && syn_ext == LEN_W'(j + 1)) begin
        fixed[j] = ~cw[j];
      end
    end
    dec_word = '0;
    for (int unsigned k = 0; k < MaxData; k++) begin
      dec_word[k] = fixed[data_pos(k) - 1];
    end

    if (req_i.command == CMD_DECODE) begin
      rsp_o.word_out      = dec_word;
      rsp_o.out_length    = m;
      rsp_o.syndrome      = syn_ext;
      rsp_o.corrected     = corr;
      rsp_o.uncorrectable = unc;
    end else begin
      rsp_o.word_out      = enc_word;
      rsp_o.out_length    = n;
      rsp_o.syndrome      = '0;
      rsp_o.corrected     = 1'b0;
      rsp_o.uncorrectable = 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ hdl/hamming_sec_encode_decode.sv @@
// Top level of the Hamming single-error-correcting encoder and decoder.
// Depends on hse_pkg and hse_core.
//
// Usage: drive req_i and raise start_i; a word is taken at every rising edge
// with start_i high and busy_o low. busy_o is always low, so a new word may be
// started in every cycle.
// The command field selects encode (data bits to codeword) or decode (check,
// correct one bit, extract data bits). data_length gives the data bit count.
// Each result appears on rsp_o for exactly one cycle with valid_o high.
// The word is registered at the input, passes the parity trees and correction
// muxes in hse_core, and is registered at the output. Throughput is one word
// per cycle. The receiver cannot stall; a result not taken in its cycle is
// gone. Reset clears the valid flags of both registers, so no result is
// shown until a word has been started after reset.
`default_nettype none

module hamming_sec_encode_decode #(
  parameter int unsigned MaxParityBits = hse_pkg::MAX_PARITY_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  hse_pkg::req_t req_i,
  output logic          valid_o,
  output hse_pkg::rsp_t rsp_o
);
  import hse_pkg::*;

  logic in_valid_q;
  req_t req_q;
  logic out_valid_q;
  rsp_t rsp_d;
  rsp_t rsp_q;
  logic accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= accept;
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (in_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  hse_core #(
    .MaxParityBits(MaxParityBits)
  ) u_core (
    .req_i(req_q),
    .rsp_o(rsp_d)
  );

  assign valid_o = out_valid_q;
  assign rsp_o   = rsp_q;

endmodule

`default_nettype wire

@@ hdl/hse_chk.sv @@
// Port checker for the Hamming codec, bound to the top level.
// Depends on hse_pkg and the assertion macros header.
`default_nettype none
`include "hamming_sec_encode_decode_macros.svh"

module hse_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_o,
  input hse_pkg::req_t req_i,
  input logic          valid_o,
  input hse_pkg::rsp_t rsp_o
);
  import hse_pkg::*;

  `HSE_ASSERT_DLY2(a_result_follows, start_i && !busy_o, valid_o, "Started word gave no result")
  `HSE_ASSERT_IMP(a_no_spurious, valid_o, $past(start_i && !busy_o, 2), "Result without a word")
  `HSE_ASSERT_IMP(a_flags_exclusive, valid_o, !(rsp_o.corrected && rsp_o.uncorrectable) && ((rsp_o.corrected || rsp_o.uncorrectable) == (rsp_o.syndrome != '0)), "Flags disagree with syndrome")
  `HSE_ASSERT_IMP(a_encode_clean, valid_o && $past(req_i.command, 2) == CMD_ENCODE, rsp_o.syndrome == '0 && !rsp_o.corrected && !rsp_o.uncorrectable, "Encode result carries decode status")

endmodule

bind hamming_sec_encode_decode hse_chk u_hse_chk (.*);

`default_nettype wire

@@ bench/hamming_sec_encode_decode_test.sv @@
// Self-checking testbench for the Hamming single-error-correcting codec.
// Drives directed and random encode and decode words, predicts each result
// and compares it field by field. Depends on hse_pkg and the block's RTL.
`default_nettype none

module hamming_sec_encode_decode_test;

  import hse_pkg::*;

  localparam int unsigned MaxDataLen = (1 << MAX_PARITY_BITS) - 1 - MAX_PARITY_BITS;
  localparam int unsigned RandomWords = 1550;

  class hamming_scoreboard;
    rsp_t        expected_rsp_q[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function rsp_t predict_hamming(req_t rq);
      int unsigned       m;
      int unsigned       r;
      int unsigned       n;
      int unsigned       k;
      int unsigned       syn;
      logic [WORD_W-1:0] w;
      logic [WORD_W-1:0] res;
      rsp_t              rs;
      m   = rq.data_length;
      w   = rq.word_in;
      res = '0;
      syn = 0;
      k   = 0;
      rs  = '0;
      if (m < 1) m = 1;
      if (m > MaxDataLen) m = MaxDataLen;
      r = 0;
      while (r < MAX_PARITY_BITS && (1 << r) < m + r + 1) r++;
      n = m + r;
      if (rq.command == CMD_ENCODE) begin
        for (int unsigned p = 1; p <= n; p++) begin
          if ((p & (p - 1)) != 0) begin
            if (w[k]) begin
              res[p-1] = 1'b1;
              syn ^= p;
            end
            k++;
          end
        end
        for (int unsigned i = 0; i < r; i++) begin
          if (((syn >> i) & 1) != 0) res[(1 << i) - 1] = 1'b1;
        end
        rs.word_out   = res;
        rs.out_length = LEN_W'(n);
      end else begin
        for (int unsigned p = 1; p <= n; p++) begin
          if (w[p-1]) syn ^= p;
        end
        if (syn != 0) begin
          if (syn <= n) begin
            w[syn-1]     = ~w[syn-1];
            rs.corrected = 1'b1;
          end else begin
            rs.uncorrectable = 1'b1;
          end
        end
        for (int unsigned p = 1; p <= n; p++) begin
          if ((p & (p - 1)) != 0) begin
            if (w[p-1]) res[k] = 1'b1;
            k++;
          end
        end
        rs.word_out   = res;
        rs.out_length = LEN_W'(m);
        rs.syndrome   = LEN_W'(syn);
      end
      return rs;
    endfunction

    function void note_word(req_t rq);
      expected_rsp_q = {expected_rsp_q, predict_hamming(rq)};
    endfunction

    function void check_word(rsp_t got);
      rsp_t want;
      if (expected_rsp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result word %p", got);
        return;
      end
      want = expected_rsp_q.pop_front();
      if (got.word_out != want.word_out || got.out_length != want.out_length ||
          got.syndrome != want.syndrome || got.corrected != want.corrected ||
          got.uncorrectable != want.uncorrectable) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: word mismatch");
          $display("  expected word %h len %0d syn %0d corr %b unc %b", want.word_out,
                   want.out_length, want.syndrome, want.corrected, want.uncorrectable);
          $display("  actual   word %h len %0d syn %0d corr %b unc %b", got.word_out,
                   got.out_length, got.syndrome, got.corrected, got.uncorrectable);
        end
      end
    endfunction
  endclass

  logic  clk_i   = 1'b0;
  logic  rst_ni  = 1'b0;
  logic  start_i = 1'b0;
  req_t  req_i   = '0;
  logic  busy_o;
  logic  valid_o;
  rsp_t  rsp_o;

  hamming_scoreboard sb;
  int unsigned       calm_left = 0;

  hamming_sec_encode_decode uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .req_i   (req_i),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) sb.check_word(rsp_o);
      if (start_i && !busy_o) sb.note_word(req_i);
    end
  end

  function automatic logic [WORD_W-1:0] random_bits();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[WORD_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] low_mask(int unsigned n);
    logic [63:0] ones;
    ones = (64'd1 << n) - 64'd1;
    return ones[WORD_W-1:0];
  endfunction

  function automatic req_t make_req(cmd_e c, logic [LEN_W-1:0] len, logic [WORD_W-1:0] w);
    req_t rq;
    rq.command     = c;
    rq.data_length = len;
    rq.word_in     = w;
    return rq;
  endfunction

  function automatic logic [WORD_W-1:0] codeword(logic [LEN_W-1:0] len,
                                                 logic [WORD_W-1:0] data);
    rsp_t rs;
    rs = sb.predict_hamming(make_req(CMD_ENCODE, len, data));
    return rs.word_out;
  endfunction

  function automatic logic [WORD_W-1:0] flip(logic [WORD_W-1:0] w, int unsigned pos);
    w[pos-1] = ~w[pos-1];
    return w;
  endfunction

  function automatic logic [LEN_W-1:0] random_length();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 4) return '0;
    if (sel < 9) return LEN_W'($urandom_range(63, MaxDataLen + 1));
    return LEN_W'($urandom_range(MaxDataLen, 1));
  endfunction

  function automatic int unsigned next_gap();
    int unsigned sel;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    sel = $urandom_range(99);
    if (sel < 2) calm_left = $urandom_range(100, 20);
    if (sel < 60) return 0;
    if (sel < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Called at a rising edge; returns at the edge that takes the word.
  task automatic send_word(req_t rq);
    logic was_free;
    req_i   <= rq;
    start_i <= 1'b1;
    do begin
      @(negedge clk_i);
      was_free = !busy_o;
      @(posedge clk_i);
    end while (!was_free);
  endtask

  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      start_i <= 1'b0;
      req_i   <= make_req(cmd_e'($urandom_range(1)), LEN_W'($urandom()), random_bits());
      @(posedge clk_i);
    end
  endtask

  initial begin
    #5_000_000;
    $display("hamming_sec_encode_decode_test NOT OK");
    $finish;
  end

  initial begin
    req_t              rq;
    rsp_t              rs;
    logic [LEN_W-1:0]  len;
    logic [WORD_W-1:0] cw;
    int unsigned       n;
    int unsigned       sel;
    int unsigned       p1;
    int unsigned       p2;
    int unsigned       drain;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(make_req(CMD_ENCODE, 6'd0, '1));
    send_word(make_req(CMD_ENCODE, 6'd1, 63'd1));
    send_word(make_req(CMD_ENCODE, 6'd57, '1));
    send_word(make_req(CMD_ENCODE, 6'd57, '0));
    send_word(make_req(CMD_ENCODE, 6'd63, '1));
    send_word(make_req(CMD_ENCODE, 6'd4, 63'b1011));
    send_word(make_req(CMD_DECODE, 6'd57, codeword(6'd57, '1)));
    send_word(make_req(CMD_DECODE, 6'd57, flip(codeword(6'd57, '1), 63)));
    send_word(make_req(CMD_DECODE, 6'd57, flip(codeword(6'd57, '1), 1)));
    send_word(make_req(CMD_DECODE, 6'd57, flip(codeword(6'd57, '0), 32)));
    send_word(make_req(CMD_DECODE, 6'd0, '1));
    send_word(make_req(CMD_DECODE, 6'd63, '0));
    send_word(make_req(CMD_DECODE, 6'd2, 63'b10100));
    send_word(make_req(CMD_DECODE, 6'd5, {{54{1'b1}}, 9'b011000000}));
    send_word(make_req(CMD_DECODE, 6'd1, flip(codeword(6'd1, 63'd1), 3)));
    send_word(make_req(CMD_DECODE, 6'd10, '1));
    send_word(make_req(CMD_DECODE, 6'd26, flip(flip(codeword(6'd26, random_bits()), 5), 20)));
    send_word(make_req(CMD_DECODE, 6'd63, flip(codeword(6'd63, random_bits()), 2)));

    for (int i = 0; i < RandomWords; i++) begin
      sel = $urandom_range(99);
      len = random_length();
      if (sel < 30) begin
        rq = make_req(CMD_ENCODE, len, random_bits());
      end else if (sel < 85) begin
        rs = sb.predict_hamming(make_req(CMD_ENCODE, len, '0));
        n  = rs.out_length;
        cw = codeword(len, random_bits());
        if ($urandom_range(3) == 0) cw |= random_bits() & ~low_mask(n);
        p1 = $urandom_range(n, 1);
        do p2 = $urandom_range(n, 1); while (p2 == p1);
        sel = $urandom_range(9);
        if (sel >= 2) cw = flip(cw, p1);
        if (sel >= 8) cw = flip(cw, p2);
        rq = make_req(CMD_DECODE, len, cw);
      end else begin
        rq = make_req(CMD_DECODE, len, random_bits());
      end
      idle_cycles(next_gap());
      send_word(rq);
    end

    start_i <= 1'b0;
    while (sb.expected_rsp_q.size() != 0) @(posedge clk_i);
    drain = 8;
    repeat (drain) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_rsp_q.size() == 0) begin
      $display("hamming_sec_encode_decode_test OK");
    end else begin
      $display("hamming_sec_encode_decode_test NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
